[rtl/core/dq_pkg.sv]
package dq_pkg;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] tag_in;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] tag_out;
    logic [6:0]  position;
    logic        last;
  } rsp_t;

  localparam logic [2:0] OP_PUSH_REAR  = 3'd0;
  localparam logic [2:0] OP_POP_FRONT  = 3'd1;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd2;
  localparam logic [2:0] OP_POP_REAR   = 3'd3;
  localparam logic [2:0] OP_LIST       = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

endpackage

[rtl/core/double_ended_queue.sv]
// Channel   Direction  Word    Handshake
// cmd       in         cmd_t   cmd_valid / cmd_stall
// rsp       out        rsp_t   rsp_valid / rsp_stall
//
// A push, and any overflow or underflow, yields one word.
// A pop yields one word, after the registered read of the tag RAM.
// A list yields one word per stored entry, one word per cycle while rsp is not stalled.
// Reset clears the pointers and the count; the tag RAM is not cleared.
// A stalled response holds the block; no command is taken until it drains.
module double_ended_queue #(
  parameter int DEPTH     = 64,
  parameter int TAG_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cmd_valid,
  output logic         cmd_stall,
  input  dq_pkg::cmd_t cmd,
  output logic         rsp_valid,
  input  logic         rsp_stall,
  output dq_pkg::rsp_t rsp
);

  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t          state;
  logic [AW-1:0]   head;
  logic [AW-1:0]   tail;
  logic [CW-1:0]   occupancy;
  logic [AW-1:0]   cur_addr;
  logic [CW-1:0]   pos;
  logic            is_list;

  logic            out_free;
  logic            take;
  logic            empty;
  logic            full;
  logic            list_done;
  logic            rsp_load;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [TAG_WIDTH-1:0] ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [TAG_WIDTH-1:0] ram_rdata;
  logic [63:0]     tag_wide;
  logic [63:0]     rd_wide;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] a);
    return (a == LAST_SLOT) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] a);
    return (a == '0) ? LAST_SLOT : a - 1'b1;
  endfunction

  assign out_free  = !rsp_valid || !rsp_stall;
  assign cmd_stall = (state != S_IDLE) || !out_free;
  assign take      = cmd_valid && !cmd_stall;
  assign empty     = (occupancy == '0);
  assign full      = (occupancy == FULL_COUNT);
  assign list_done = (pos == occupancy);
  assign tag_wide  = 64'(cmd.tag_in);
  assign ram_wdata = tag_wide[TAG_WIDTH-1:0];
  assign rd_wide   = 64'(ram_rdata);

  assign rsp_load = (state == S_READ) ? out_free :
                    (take && (cmd.opcode inside {OP_PUSH_REAR, OP_PUSH_FRONT} ||
                              (empty && cmd.opcode inside {OP_POP_FRONT, OP_POP_REAR,
                                                           OP_LIST})));

  // Writes happen only when a command is taken in idle and reads of the same
  // entry come no earlier than the cycle after the write, so no forwarding is needed.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail;
    ram_re    = 1'b0;
    ram_raddr = head;
    if (take) begin
      unique case (cmd.opcode) inside
        OP_PUSH_REAR: begin
          ram_we    = !full;
          ram_waddr = tail;
        end
        OP_PUSH_FRONT: begin
          ram_we    = !full;
          ram_waddr = prev_slot(head);
        end
        OP_POP_FRONT, OP_LIST: begin
          ram_re    = !empty;
          ram_raddr = head;
        end
        OP_POP_REAR: begin
          ram_re    = !empty;
          ram_raddr = prev_slot(tail);
        end
        default: begin
        end
      endcase
    end else if (state == S_READ && out_free && is_list && !list_done) begin
      ram_re    = 1'b1;
      ram_raddr = next_slot(cur_addr);
    end
  end

  dq_ram #(
    .WIDTH(TAG_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      occupancy <= '0;
      cur_addr  <= '0;
      pos       <= '0;
      is_list   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            unique case (cmd.opcode) inside
              OP_PUSH_REAR, OP_PUSH_FRONT: begin
                rsp_valid <= 1'b1;
                rsp <= '{status: (full ? ST_OVERFLOW : ST_OK), tag_out: '0,
                         position: '0, last: 1'b1};
                if (!full) begin
                  occupancy <= occupancy + 1'b1;
                  if (cmd.opcode == OP_PUSH_REAR) begin
                    tail <= next_slot(tail);
                  end else begin
                    head <= prev_slot(head);
                  end
                end
              end
              OP_POP_FRONT, OP_POP_REAR, OP_LIST: begin
                if (empty) begin
                  rsp_valid <= 1'b1;
                  rsp <= '{status: ST_UNDERFLOW, tag_out: '0, position: '0,
                           last: 1'b1};
                end else begin
                  state    <= S_READ;
                  cur_addr <= ram_raddr;
                  pos      <= CW'(1);
                  is_list  <= (cmd.opcode == OP_LIST);
                  if (cmd.opcode == OP_POP_FRONT) begin
                    head      <= next_slot(head);
                    occupancy <= occupancy - 1'b1;
                  end else if (cmd.opcode == OP_POP_REAR) begin
                    tail      <= prev_slot(tail);
                    occupancy <= occupancy - 1'b1;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            rsp <= '{status: ST_OK, tag_out: rd_wide[31:0],
                     position: (is_list ? 7'(pos) : 7'd0),
                     last: (!is_list || list_done)};
            if (is_list && !list_done) begin
              pos      <= pos + 1'b1;
              cur_addr <= next_slot(cur_addr);
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("tag RAM read and write in the same cycle");

  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (head != tail) |-> (occupancy != '0 && occupancy != FULL_COUNT))
    else $error("pointers disagree with occupancy");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (take && !full && (cmd.opcode == OP_PUSH_REAR || cmd.opcode == OP_PUSH_FRONT))
    |=> (occupancy == $past(occupancy) + 1'b1))
    else $error("push did not grow the queue");

  a_list_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ && is_list) |-> (pos != '0 && pos <= occupancy))
    else $error("list position out of range");

endmodule

[rtl/core/dq_ram.sv]
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[test/double_ended_queue_test.sv]
module double_ended_queue_test;
  import dq_pkg::*;

  localparam int DEPTH        = 64;
  localparam int TAG_WIDTH    = 32;
  localparam int RANDOM_OPS   = 250;
  localparam int PHASE_LEN    = 40;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int MAX_REPORTS  = 100;

  localparam logic [2:0] OP_FIRST_UNUSED = OP_LIST + 3'd1;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

  typedef enum logic [1:0] {
    PH_STEADY,
    PH_SEND_GAPS,
    PH_RECV_STALLS,
    PH_BOTH
  } idle_phase_e;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  idle_phase_e idle_phase = PH_STEADY;
  int          send_idle_pct;
  int          recv_stall_pct;

  cmd_t cmd_q[$];
  rsp_t reply_q[$];

  logic [TAG_WIDTH-1:0] ring [DEPTH];
  int unsigned front_ix = 0;
  int unsigned rear_ix  = 0;
  int unsigned fill     = 0;
  int unsigned peak_fill = 0;

  int n_items     = 0;
  int n_issued    = 0;
  int n_taken     = 0;
  int n_words     = 0;
  int n_overflow  = 0;
  int n_underflow = 0;
  int n_errors    = 0;
  int quiet_cycles = 0;

  double_ended_queue #(
    .DEPTH    (DEPTH),
    .TAG_WIDTH(TAG_WIDTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #5 clk = ~clk;

  always_comb begin
    case (idle_phase)
      PH_SEND_GAPS: begin
        send_idle_pct  = 60;
        recv_stall_pct = 0;
      end
      PH_RECV_STALLS: begin
        send_idle_pct  = 0;
        recv_stall_pct = 60;
      end
      PH_BOTH: begin
        send_idle_pct  = 25;
        recv_stall_pct = 25;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  end

  task automatic deque_apply(input cmd_t c);
    rsp_t w;
    int   i;
    w      = '0;
    w.last = 1'b1;
    case (c.opcode)
      OP_PUSH_REAR, OP_PUSH_FRONT: begin
        if (fill == DEPTH) begin
          w.status = ST_OVERFLOW;
          n_overflow++;
        end else if (c.opcode == OP_PUSH_REAR) begin
          ring[rear_ix] = c.tag_in[TAG_WIDTH-1:0];
          rear_ix = (rear_ix + 1) % DEPTH;
          fill++;
        end else begin
          front_ix = (front_ix + DEPTH - 1) % DEPTH;
          ring[front_ix] = c.tag_in[TAG_WIDTH-1:0];
          fill++;
        end
        reply_q.push_back(w);
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (fill == 0) begin
          w.status = ST_UNDERFLOW;
          n_underflow++;
        end else if (c.opcode == OP_POP_FRONT) begin
          w.tag_out = 32'(ring[front_ix]);
          front_ix = (front_ix + 1) % DEPTH;
          fill--;
        end else begin
          rear_ix = (rear_ix + DEPTH - 1) % DEPTH;
          w.tag_out = 32'(ring[rear_ix]);
          fill--;
        end
        reply_q.push_back(w);
      end
      OP_LIST: begin
        if (fill == 0) begin
          w.status = ST_UNDERFLOW;
          n_underflow++;
          reply_q.push_back(w);
        end else begin
          for (i = 0; i < fill; i++) begin
            w.tag_out  = 32'(ring[(front_ix + i) % DEPTH]);
            w.position = 7'(i + 1);
            w.last     = (i + 1 == fill);
            reply_q.push_back(w);
          end
        end
      end
      default: begin
      end
    endcase
    if (fill > peak_fill) peak_fill = fill;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || !cmd_stall) begin
      if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd       <= cmd_q.pop_front();
        cmd_valid <= 1'b1;
        n_issued++;
        idle_phase <= idle_phase_e'((n_issued / PHASE_LEN) % 4);
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        deque_apply(cmd);
        n_taken++;
      end
      if (rsp_valid && !rsp_stall) begin
        if (reply_q.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: unexpected word: expected none, got status=%0d tag=%h pos=%0d last=%b",
                     $time, rsp.status, rsp.tag_out, rsp.position, rsp.last);
        end else begin
          want = reply_q.pop_front();
          n_words++;
          if (rsp.status !== want.status || rsp.tag_out !== want.tag_out ||
              rsp.position !== want.position || rsp.last !== want.last) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("%0t: expected %0d %h %0d %b, got %0d %h %0d %b (status tag pos last)",
                       $time, want.status, want.tag_out, want.position, want.last,
                       rsp.status, rsp.tag_out, rsp.position, rsp.last);
          end
        end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout with %0d words still expected", $time, reply_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic add_cmd(input logic [2:0] op, input logic [31:0] tag);
    cmd_t c;
    c.opcode = op;
    c.tag_in = tag;
    cmd_q.push_back(c);
    n_items++;
  endtask

  task automatic add_random(input int push_pct, input int pop_pct, input int list_pct);
    int         r;
    logic [2:0] op;
    r = $urandom_range(99);
    if (r < push_pct)
      op = $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
    else if (r < push_pct + pop_pct)
      op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
    else if (r < push_pct + pop_pct + list_pct)
      op = OP_LIST;
    else
      op = 3'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
    add_cmd(op, $urandom());
  endtask

  initial begin
    int b;
    int k;

    add_cmd(OP_LIST, $urandom());
    add_cmd(OP_POP_FRONT, $urandom());
    add_cmd(OP_POP_REAR, $urandom());
    add_cmd(OP_PUSH_REAR, 32'h0000_0000);
    add_cmd(OP_PUSH_REAR, 32'hFFFF_FFFF);
    add_cmd(OP_PUSH_FRONT, 32'h8000_0000);
    add_cmd(OP_PUSH_FRONT, 32'h0000_0001);
    add_cmd(OP_LIST, $urandom());
    add_cmd(OP_FIRST_UNUSED, $urandom());
    add_cmd(OP_FIRST_UNUSED + 3'd1, $urandom());
    add_cmd(OP_LAST_UNUSED, $urandom());
    add_cmd(OP_POP_FRONT, $urandom());
    add_cmd(OP_POP_REAR, $urandom());
    add_cmd(OP_LIST, $urandom());
    add_cmd(OP_POP_FRONT, $urandom());
    add_cmd(OP_POP_REAR, $urandom());
    add_cmd(OP_POP_REAR, $urandom());
    add_cmd(OP_PUSH_FRONT, 32'h5A5A_5A5A);
    add_cmd(OP_POP_REAR, $urandom());
    add_cmd(OP_PUSH_REAR, 32'hA5A5_A5A5);
    add_cmd(OP_POP_FRONT, $urandom());
    add_cmd(OP_LIST, $urandom());

    // Alternate bursts that overfill, drain past empty, and churn at random.
    for (b = 0; n_items < RANDOM_OPS; b++) begin
      case (b % 3)
        0: begin
          for (k = 0; k < 75; k++) add_random(92, 0, 5);
          add_cmd(OP_LIST, $urandom());
        end
        1: for (k = 0; k < 75; k++) add_random(0, 92, 5);
        default: for (k = 0; k < 30; k++) add_random(40, 40, 15);
      endcase
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (n_taken < n_items || reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands with %0d overflows and %0d underflows.",
             n_items, n_overflow, n_underflow);
    $display("Checked %0d reply words; the queue held up to %0d of %0d tags.",
             n_words, peak_fill, DEPTH);
    if (n_errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/dq_pkg.sv
rtl/core/dq_ram.sv
rtl/core/double_ended_queue.sv
test/double_ended_queue_test.sv
